[sv/isotp_pkg.sv]
// Shared types and codes for the ISO-TP receive reassembler.
// Used by isotp_front, isotp_queue, isotp_back and the top level; no dependencies.
package isotp_pkg;

  typedef enum logic [1:0] {
    EV_BYTE     = 2'd0,
    EV_FC       = 2'd1,
    EV_SEQ_ERR  = 2'd2,
    EV_IGNORED  = 2'd3
  } event_e;

  // PCI frame types (upper nibble of byte 0)
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd1;

  localparam logic [3:0]  SEQ_RESET   = 4'd1;
  localparam logic [11:0] BYTES_RESET = 12'd6;

  // one classified frame: up to seven payload beats, then an optional
  // flow-control beat; with neither, a single status beat of code ev
  typedef struct packed {
    event_e           ev;
    logic [3:0]       ch;
    logic [6:0][7:0]  data;      // data[0] goes out first
    logic [2:0]       cnt;
    logic [11:0]      base_off;
    logic [11:0]      msg_len;
    logic             has_done;  // last payload beat completes the message
    logic             fc;
    logic [7:0]       fc_bs;
  } job_t;

  typedef struct packed {
    event_e      ev;
    logic [3:0]  ch;
    logic [7:0]  payload;
    logic [11:0] off;
    logic [11:0] len;
    logic        done;
    logic [7:0]  bs;
    logic        last;
  } res_t;

endpackage

[sv/isotp_front.sv]
// Front end: configuration registers, reassembly state and frame classification.
// Depends on isotp_pkg; pushes one isotp_pkg::job_t per accepted frame.
module isotp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [isotp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                      cfg_data_i,
  input  logic                            push_i,
  input  logic [3:0]                      channel_i,
  input  logic [3:0]                      frame_length_i,
  input  logic [7:0][7:0]                 frame_i,
  output isotp_pkg::job_t                 job_o
);

  logic [7:0]  block_size_q;
  logic [6:0]  max_len_q;
  logic        busy_q, busy_d;
  logic [3:0]  seq_q, seq_d;
  logic [11:0] rcvd_q, rcvd_d;
  logic [11:0] total_q, total_d;
  logic [7:0]  left_q, left_d;

  logic [3:0]  pci_type, pci_low;
  logic [11:0] ff_total, remain;
  logic [7:0]  left_dec;
  logic        cf_done;

  always_comb begin
    pci_type = frame_i[0][7:4];
    pci_low  = frame_i[0][3:0];
    ff_total = {pci_low, frame_i[1]};
    remain   = total_q - rcvd_q;
    cf_done  = (remain != 12'd0) && (remain <= 12'd7);
    left_dec = left_q - 8'd1;

    job_o.ev       = isotp_pkg::EV_IGNORED;
    job_o.ch       = channel_i;
    job_o.data     = frame_i[7:1];
    job_o.cnt      = 3'd0;
    job_o.base_off = 12'd0;
    job_o.msg_len  = 12'd0;
    job_o.has_done = 1'b0;
    job_o.fc       = 1'b0;
    job_o.fc_bs    = block_size_q;

    busy_d  = busy_q;
    seq_d   = seq_q;
    rcvd_d  = rcvd_q;
    total_d = total_q;
    left_d  = left_q;

    case (pci_type)
      isotp_pkg::PCI_SF: begin
        if ((pci_low != 4'd0) && (pci_low <= 4'd7) && (pci_low < frame_length_i)) begin
          job_o.cnt      = pci_low[2:0];
          job_o.msg_len  = {8'd0, pci_low};
          job_o.has_done = 1'b1;
        end
      end
      isotp_pkg::PCI_FF: begin
        if (!busy_q && (frame_length_i != 4'd0) &&
            ({3'd0, frame_length_i} <= max_len_q) && (ff_total >= 12'd7)) begin
          job_o.data    = {8'd0, frame_i[7:2]};
          job_o.cnt     = 3'd6;
          job_o.msg_len = ff_total;
          job_o.fc      = 1'b1;
          job_o.ev      = isotp_pkg::EV_BYTE;
          busy_d  = 1'b1;
          seq_d   = isotp_pkg::SEQ_RESET;
          rcvd_d  = isotp_pkg::BYTES_RESET;
          total_d = ff_total;
          left_d  = block_size_q;
        end
      end
      isotp_pkg::PCI_CF: begin
        if (busy_q) begin
          if (pci_low != seq_q) begin
            job_o.ev = isotp_pkg::EV_SEQ_ERR;
            busy_d   = 1'b0;
            seq_d    = isotp_pkg::SEQ_RESET;
            rcvd_d   = isotp_pkg::BYTES_RESET;
          end else begin
            job_o.ev       = isotp_pkg::EV_BYTE;
            job_o.cnt      = cf_done ? remain[2:0] : 3'd7;
            job_o.base_off = rcvd_q;
            job_o.msg_len  = total_q;
            job_o.has_done = cf_done;
            seq_d = seq_q + 4'd1;
            if (cf_done) begin
              busy_d = 1'b0;
              seq_d  = isotp_pkg::SEQ_RESET;
              rcvd_d = isotp_pkg::BYTES_RESET;
            end else begin
              rcvd_d = rcvd_q + 12'd7;
              if (left_q != 8'd0) begin
                // block boundary: ask for the next flow control
                if (left_dec == 8'd0) begin
                  job_o.fc = 1'b1;
                  left_d   = block_size_q;
                end else begin
                  left_d = left_dec;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= 8'd8;
      max_len_q    <= 7'd8;
      busy_q       <= 1'b0;
      seq_q        <= isotp_pkg::SEQ_RESET;
      rcvd_q       <= isotp_pkg::BYTES_RESET;
      total_q      <= 12'd0;
      left_q       <= 8'd0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == isotp_pkg::CFG_BLOCK_SIZE) begin
          block_size_q <= cfg_data_i;
        end else if (cfg_index_i == isotp_pkg::CFG_MAX_LEN) begin
          max_len_q <= cfg_data_i[6:0];
        end
      end
      if (push_i) begin
        busy_q  <= busy_d;
        seq_q   <= seq_d;
        rcvd_q  <= rcvd_d;
        total_q <= total_d;
        left_q  <= left_d;
      end
    end
  end

endmodule

[sv/isotp_queue.sv]
// Small FIFO of classified frames between front and back end.
// Depends on isotp_pkg (job_t).
module isotp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  isotp_pkg::job_t push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output isotp_pkg::job_t pop_job_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  isotp_pkg::job_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntFull);
  assign valid_o   = (cnt_q != '0);
  assign pop_job_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[sv/isotp_back.sv]
// Back end: walks one queued job beat by beat into the output register.
// Depends on isotp_pkg (job_t, res_t, event codes).
module isotp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  isotp_pkg::job_t q_job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output isotp_pkg::res_t res_o
);

  isotp_pkg::job_t cur_q;
  logic            cur_valid_q;
  logic [2:0]      idx_q;
  logic            out_valid_q;
  isotp_pkg::res_t res_q, res_d;
  logic            adv, fire;

  always_comb begin
    res_d.ch      = cur_q.ch;
    res_d.payload = 8'd0;
    res_d.off     = 12'd0;
    res_d.len     = 12'd0;
    res_d.done    = 1'b0;
    res_d.bs      = 8'd0;
    res_d.last    = 1'b1;
    if (idx_q < cur_q.cnt) begin
      res_d.ev      = isotp_pkg::EV_BYTE;
      res_d.payload = cur_q.data[idx_q];
      res_d.off     = cur_q.base_off + {9'd0, idx_q};
      res_d.len     = cur_q.msg_len;
      res_d.done    = cur_q.has_done && (idx_q == cur_q.cnt - 3'd1);
      res_d.last    = (idx_q == cur_q.cnt - 3'd1) && !cur_q.fc;
    end else if (cur_q.fc) begin
      res_d.ev  = isotp_pkg::EV_FC;
      res_d.len = cur_q.msg_len;
      res_d.bs  = cur_q.fc_bs;
    end else begin
      res_d.ev = cur_q.ev;
    end
  end

  assign adv         = !out_valid_q || !out_stall_i;
  assign fire        = cur_valid_q && adv;
  assign pop_o       = q_valid_i && (!cur_valid_q || (fire && res_d.last));
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_job_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= cur_valid_q;
      end
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 3'd0;
      end else if (fire && res_d.last) begin
        cur_valid_q <= 1'b0;
      end else if (fire) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule

[sv/isotp_receive_reassembler.sv]
// ISO-TP receive reassembler: one CAN frame in, a burst of byte-wide results out.
// Depends on isotp_pkg, isotp_front, isotp_queue and isotp_back.
//
// A frame beat is taken whenever the job queue has room, so frames may arrive
// in consecutive cycles. Each frame yields 1 to 8 result beats (single frame:
// its payload bytes; first frame: six bytes plus a flow-control request;
// consecutive frame: up to seven bytes, plus flow control at block ends;
// anything rejected: one status beat). The back-end sequencer drives one beat
// per cycle while out_stall_i is low, through a single output register; the
// front end only stalls once QDEPTH frames are queued behind the one being
// emitted. Reassembly state is updated at frame accept time, so the queue
// never holds state dependencies. There is no clearing pass after reset.
// Configuration writes are always ready and take effect in the next cycle;
// index 0 is block_size, index 1 max_frame_length, other indexes are dropped.
module isotp_receive_reassembler #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [isotp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                      cfg_data_i,
  // frame input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [3:0]                      channel_i,
  input  logic [3:0]                      frame_length_i,
  input  logic [7:0]                      frame_byte_0_i,
  input  logic [7:0]                      frame_byte_1_i,
  input  logic [7:0]                      frame_byte_2_i,
  input  logic [7:0]                      frame_byte_3_i,
  input  logic [7:0]                      frame_byte_4_i,
  input  logic [7:0]                      frame_byte_5_i,
  input  logic [7:0]                      frame_byte_6_i,
  input  logic [7:0]                      frame_byte_7_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      event_res_o,
  output logic [3:0]                      out_channel_o,
  output logic [7:0]                      payload_byte_o,
  output logic [11:0]                     byte_offset_o,
  output logic [11:0]                     message_length_o,
  output logic                            message_done_o,
  output logic [7:0]                      fc_block_size_o,
  output logic                            last_o
);

  logic            push, q_full, q_valid, pop;
  logic [7:0][7:0] frame;
  isotp_pkg::job_t push_job, pop_job;
  isotp_pkg::res_t res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign push        = in_valid_i && !q_full;

  assign frame = {frame_byte_7_i, frame_byte_6_i, frame_byte_5_i, frame_byte_4_i,
                  frame_byte_3_i, frame_byte_2_i, frame_byte_1_i, frame_byte_0_i};

  // classify and update reassembly state on accept
  isotp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push),
    .channel_i      (channel_i),
    .frame_length_i (frame_length_i),
    .frame_i        (frame),
    .job_o          (push_job)
  );

  // decouples frame acceptance from result streaming
  isotp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  // one result beat per cycle unless the sink stalls
  isotp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign event_res_o      = res.ev;
  assign out_channel_o    = res.ch;
  assign payload_byte_o   = res.payload;
  assign byte_offset_o    = res.off;
  assign message_length_o = res.len;
  assign message_done_o   = res.done;
  assign fc_block_size_o  = res.bs;
  assign last_o           = res.last;

endmodule

[tb/sv/tb_isotp_receive_reassembler.sv]
// Self-checking testbench for isotp_receive_reassembler: CAN frames in, byte-wide results out.
// Needs isotp_pkg and the reassembler RTL; predicts every result beat and compares it
// with the block's output stream under random source gaps and sink stalls.
module tb_isotp_receive_reassembler;
  timeunit 1ns;
  timeprecision 1ps;

  // PCI type of a flow-control frame; the receiver never accepts one
  localparam logic [3:0] PCI_FC = 4'h3;

  localparam int HOLD_CYCLES    = 150;   // long sink hold-off for the backpressure test
  localparam int SETTLE_CYCLES  = 12;    // > one frame's worth of result beats
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat moving on any channel
  localparam int MAX_CF_PER_MSG = 40;    // long messages are cut short to bound run time
  localparam int RANDOM_FRAMES  = 150;

  typedef struct packed {
    logic [3:0]      ch;
    logic [3:0]      flen;
    logic [7:0][7:0] data;  // data[0] is the PCI byte
  } can_frame_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                            cfg_valid;
  logic                            cfg_ready_o;
  logic [isotp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                      cfg_data;

  logic            frame_valid;
  logic            in_stall_o;
  logic [3:0]      frame_ch;
  logic [3:0]      frame_len;
  logic [7:0][7:0] frame_bytes;

  logic        out_valid_o;
  logic        res_stall;
  logic [1:0]  event_res_o;
  logic [3:0]  out_channel_o;
  logic [7:0]  payload_byte_o;
  logic [11:0] byte_offset_o;
  logic [11:0] message_length_o;
  logic        message_done_o;
  logic [7:0]  fc_block_size_o;
  logic        last_o;

  // shadow of the receiver: configuration and reassembly state
  logic [7:0]  bs_reg;
  logic [6:0]  max_len_reg;
  logic        receiving;
  logic [3:0]  next_sn;
  logic [11:0] msg_pos;
  logic [11:0] msg_total;
  logic [7:0]  block_left;

  // result beats predicted but not yet seen on the output, oldest first
  isotp_pkg::res_t result_beats[$];

  int  mismatches  = 0;
  int  frames_sent = 0;  // every frame beat taken by the block
  int  quiet_cycles = 0;
  bit  gaps_on = 1'b1;   // random source gaps and sink stalls
  bit  hold_req = 1'b0;  // ask the sink for one long hold-off

  always #10 clk_i = ~clk_i;

  isotp_receive_reassembler DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (frame_valid),
    .in_stall_o       (in_stall_o),
    .channel_i        (frame_ch),
    .frame_length_i   (frame_len),
    .frame_byte_0_i   (frame_bytes[0]),
    .frame_byte_1_i   (frame_bytes[1]),
    .frame_byte_2_i   (frame_bytes[2]),
    .frame_byte_3_i   (frame_bytes[3]),
    .frame_byte_4_i   (frame_bytes[4]),
    .frame_byte_5_i   (frame_bytes[5]),
    .frame_byte_6_i   (frame_bytes[6]),
    .frame_byte_7_i   (frame_bytes[7]),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (res_stall),
    .event_res_o      (event_res_o),
    .out_channel_o    (out_channel_o),
    .payload_byte_o   (payload_byte_o),
    .byte_offset_o    (byte_offset_o),
    .message_length_o (message_length_o),
    .message_done_o   (message_done_o),
    .fc_block_size_o  (fc_block_size_o),
    .last_o           (last_o)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic isotp_pkg::res_t beat(isotp_pkg::event_e ev, logic [3:0] ch,
                                           logic [7:0] payload, logic [11:0] off,
                                           logic [11:0] len, logic done, logic [7:0] bs);
    isotp_pkg::res_t r;
    r.ev = ev;  r.ch = ch;  r.payload = payload;  r.off = off;
    r.len = len;  r.done = done;  r.bs = bs;  r.last = 1'b0;
    return r;
  endfunction

  // Apply one accepted frame to the shadow state and queue the beats it causes.
  function automatic void reassemble_frame(can_frame_t f);
    isotp_pkg::res_t burst[$];
    logic [3:0]      ptype;
    logic [3:0]      low;
    logic [11:0]     tot;
    logic [11:0]     off;
    logic            done;
    int              i;
    ptype = f.data[0][7:4];
    low   = f.data[0][3:0];
    if (ptype == isotp_pkg::PCI_SF) begin
      // length nibble must be 1..7 and fit in the frame behind the PCI byte
      if (low == 4'd0 || low > 4'd7 || low >= f.flen) begin
        burst.push_back(beat(isotp_pkg::EV_IGNORED, f.ch, '0, '0, '0, 1'b0, '0));
      end else begin
        for (i = 0; i < low; i++)
          burst.push_back(beat(isotp_pkg::EV_BYTE, f.ch, f.data[i+1], 12'(i),
                               {8'd0, low}, (i + 1 == low), '0));
      end
    end else if (ptype == isotp_pkg::PCI_FF) begin
      tot = {low, f.data[1]};
      if (receiving || f.flen == 4'd0 || f.flen > max_len_reg || tot < 12'd7) begin
        burst.push_back(beat(isotp_pkg::EV_IGNORED, f.ch, '0, '0, '0, 1'b0, '0));
      end else begin
        msg_total = tot;
        for (i = 0; i < 6; i++)
          burst.push_back(beat(isotp_pkg::EV_BYTE, f.ch, f.data[i+2], 12'(i), tot,
                               1'b0, '0));
        burst.push_back(beat(isotp_pkg::EV_FC, f.ch, '0, '0, tot, 1'b0, bs_reg));
        receiving  = 1'b1;
        next_sn    = isotp_pkg::SEQ_RESET;
        msg_pos    = isotp_pkg::BYTES_RESET;
        block_left = bs_reg;
      end
    end else if (ptype == isotp_pkg::PCI_CF) begin
      if (!receiving) begin
        burst.push_back(beat(isotp_pkg::EV_IGNORED, f.ch, '0, '0, '0, 1'b0, '0));
      end else if (low != next_sn) begin
        // abort: back to idle, block counter and total are left alone
        burst.push_back(beat(isotp_pkg::EV_SEQ_ERR, f.ch, '0, '0, '0, 1'b0, '0));
        receiving = 1'b0;
        next_sn   = isotp_pkg::SEQ_RESET;
        msg_pos   = isotp_pkg::BYTES_RESET;
      end else begin
        done = 1'b0;
        for (i = 1; i <= 7 && !done; i++) begin
          off     = msg_pos;
          msg_pos = msg_pos + 12'd1;
          done    = (msg_pos == msg_total);
          burst.push_back(beat(isotp_pkg::EV_BYTE, f.ch, f.data[i], off, msg_total,
                               done, '0));
        end
        next_sn = next_sn + 4'd1;
        if (done) begin
          receiving = 1'b0;
          next_sn   = isotp_pkg::SEQ_RESET;
          msg_pos   = isotp_pkg::BYTES_RESET;
        end else if (block_left != 8'd0) begin
          // a zero block size never counts down, so only one FC per message
          block_left = block_left - 8'd1;
          if (block_left == 8'd0) begin
            burst.push_back(beat(isotp_pkg::EV_FC, f.ch, '0, '0, msg_total, 1'b0,
                                 bs_reg));
            block_left = bs_reg;
          end
        end
      end
    end else begin
      burst.push_back(beat(isotp_pkg::EV_IGNORED, f.ch, '0, '0, '0, 1'b0, '0));
    end
    burst[burst.size()-1].last = 1'b1;
    foreach (burst[j]) result_beats.push_back(burst[j]);
  endfunction

  // ---------------------------------------------------------------------------
  // Frame construction and driving
  // ---------------------------------------------------------------------------

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic can_frame_t make_frame(logic [7:0] pci, logic [3:0] flen);
    can_frame_t f;
    int k;
    f.ch   = 4'($urandom_range(0, 15));
    f.flen = flen;
    for (k = 1; k < 8; k++) f.data[k] = 8'($urandom_range(0, 255));
    f.data[0] = pci;
    return f;
  endfunction

  // any PCI byte at all: every frame type, valid or broken
  function automatic can_frame_t noise_frame();
    return make_frame(8'($urandom_range(0, 255)), 4'($urandom_range(0, 8)));
  endfunction

  function automatic can_frame_t good_single_frame();
    logic [3:0] low;
    low = 4'($urandom_range(1, 7));
    return make_frame({isotp_pkg::PCI_SF, low}, 4'($urandom_range(low + 1, 8)));
  endfunction

  // Offer one frame, hold it until the beat is taken, then maybe idle.
  // Valid is only dropped when a gap follows, so back-to-back frames keep it high.
  task automatic send_frame(can_frame_t f);
    int gap;
    frame_valid <= 1'b1;
    frame_ch    <= f.ch;
    frame_len   <= f.flen;
    frame_bytes <= f.data;
    do @(posedge clk_i); while (in_stall_o);
    reassemble_frame(f);
    frames_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // First frame plus its consecutive frames; noise_pct is the chance of a stray
  // frame before each CF, which may abort or disturb the transfer.
  task automatic send_message(int total, int noise_pct);
    can_frame_t  f;
    logic [11:0] tot;
    logic [3:0]  sn;
    int          ncf, k, fl_hi;
    tot   = 12'(total);
    fl_hi = (max_len_reg < 8) ? int'(max_len_reg) : 8;
    f = make_frame({isotp_pkg::PCI_FF, tot[11:8]}, 4'($urandom_range(1, fl_hi)));
    f.data[1] = tot[7:0];
    send_frame(f);
    ncf = total / 7;  // six bytes ride in the FF, seven per CF
    if (ncf > MAX_CF_PER_MSG) ncf = MAX_CF_PER_MSG;
    sn = isotp_pkg::SEQ_RESET;
    for (k = 0; k < ncf; k++) begin
      if ($urandom_range(1, 100) <= noise_pct) send_frame(noise_frame());
      send_frame(make_frame({isotp_pkg::PCI_CF, sn}, 4'($urandom_range(0, 8))));
      sn = sn + 4'd1;
    end
  endtask

  // Stop offering frames and wait until every predicted beat has come out.
  task automatic drain_results();
    frame_valid <= 1'b0;
    while (result_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; only done with the block drained.
  task automatic configure(logic [7:0] bs, logic [7:0] max_len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= isotp_pkg::CFG_BLOCK_SIZE;
    cfg_data  <= bs;
    do @(posedge clk_i); while (!cfg_ready_o);
    bs_reg = bs;
    cfg_index <= isotp_pkg::CFG_MAX_LEN;
    cfg_data  <= max_len;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_len_reg = max_len[6:0];
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every frame type and every reject path but max_frame_length, reset configuration.
  task automatic test_directed();
    can_frame_t f;
    f = make_frame({isotp_pkg::PCI_SF, 4'd1}, 4'd2);  // shortest SF, all-zero bytes
    f.data = '0;  f.data[0] = {isotp_pkg::PCI_SF, 4'd1};  f.ch = 4'd0;
    send_frame(f);
    f = make_frame({isotp_pkg::PCI_SF, 4'd7}, 4'd8);  // longest SF, all-ones bytes
    f.data = '1;  f.data[0] = {isotp_pkg::PCI_SF, 4'd7};  f.ch = 4'd15;
    send_frame(f);
    send_frame(make_frame({isotp_pkg::PCI_SF, 4'd0}, 4'd8));  // SF length zero
    send_frame(make_frame({isotp_pkg::PCI_SF, 4'd8}, 4'd8));  // SF length above seven
    send_frame(make_frame({isotp_pkg::PCI_SF, 4'd4}, 4'd4));  // SF length not below frame length
    send_frame(make_frame({isotp_pkg::PCI_CF, isotp_pkg::SEQ_RESET}, 4'd8));  // CF while idle
    send_frame(make_frame({PCI_FC, 4'd0}, 4'd3));       // flow control frame
    send_frame(make_frame(8'hF5, 4'd8));                // unknown type
    f = make_frame({isotp_pkg::PCI_FF, 4'd0}, 4'd0);  f.data[1] = 8'd20;  // FF frame length zero
    send_frame(f);
    f = make_frame({isotp_pkg::PCI_FF, 4'd0}, 4'd8);  f.data[1] = 8'd6;   // FF total below seven
    send_frame(f);
    f = make_frame({isotp_pkg::PCI_FF, 4'd0}, 4'd8);  f.data[1] = 8'd7;   // smallest message
    send_frame(f);
    send_frame(make_frame({isotp_pkg::PCI_CF, 4'd1}, 4'd8));  // one byte, done
    f = make_frame({isotp_pkg::PCI_FF, 4'hF}, 4'd8);  f.data[1] = 8'hFF;  // largest total
    send_frame(f);
    f = make_frame({isotp_pkg::PCI_FF, 4'd0}, 4'd8);  f.data[1] = 8'd10;  // FF while busy
    send_frame(f);
    send_frame(good_single_frame());                    // SF while busy
    send_frame(make_frame({isotp_pkg::PCI_CF, 4'd1}, 4'd8));
    send_frame(make_frame({isotp_pkg::PCI_CF, 4'd3}, 4'd8));  // sequence error
    send_frame(make_frame({isotp_pkg::PCI_CF, 4'd2}, 4'd8));  // now idle again
    send_message(20, 0);  // last CF ends exactly on its seventh byte
  endtask

  // Flow control cadence across block sizes, including zero and the extremes.
  task automatic test_block_size();
    configure(8'd1, 8'd64);
    send_message(40, 0);
    configure(8'd0, 8'd64);
    send_message(60, 0);
    configure(8'd255, 8'd64);
    send_message(125, 0);  // sequence number wraps past 15
    configure(8'd2, 8'd8);
    send_message(30, 0);
  endtask

  // First frames longer than max_frame_length are rejected.
  task automatic test_frame_limit();
    can_frame_t f;
    configure(8'd8, 8'd1);
    f = make_frame({isotp_pkg::PCI_FF, 4'd0}, 4'd2);  f.data[1] = 8'd12;
    send_frame(f);
    send_message(12, 0);
    configure(8'd3, 8'd5);
    f = make_frame({isotp_pkg::PCI_FF, 4'd0}, 4'd6);  f.data[1] = 8'd12;
    send_frame(f);
    send_message(33, 0);
  endtask

  // Sink holds off for a long stretch while frames keep coming back to back,
  // so the job queue fills and the input stalls.
  task automatic test_backpressure();
    configure(8'd4, 8'd64);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_message(62, 0);
    gaps_on = 1'b1;
    drain_results();
  endtask

  // Mostly well-formed transfers with random content, some stray and broken frames.
  task automatic test_random();
    int phase, r, total, target;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: configure(8'd3, 8'd64);
        1: configure(8'd0, 8'd8);
        2: configure(8'd255, 8'd3);
        3: configure(8'd1, 8'd64);
        default: configure(8'd8, 8'd8);
      endcase
      gaps_on = (phase != 3);  // one phase runs flat out on both sides
      target = frames_sent + RANDOM_FRAMES / 5;
      while (frames_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          r = $urandom_range(0, 99);
          if (r < 80)      total = $urandom_range(7, 60);
          else if (r < 95) total = $urandom_range(61, 200);
          else             total = $urandom_range(7, 4095);
          send_message(total, 8);
        end else if (r < 75) begin
          send_frame(good_single_frame());
        end else if (r < 96) begin
          send_frame(noise_frame());
        end else begin
          drain_results();  // sender pauses until every beat is out
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : drive_result_stall
    int n;
    res_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        res_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        n = pick_gap() + 1;
        res_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        res_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    isotp_pkg::res_t want;
    if (rst_ni && out_valid_o && !res_stall) begin
      if (result_beats.size() == 0) begin
        $error("result beat with nothing predicted: event %0d channel %0d",
               event_res_o, out_channel_o);
        mismatches++;
      end else begin
        want = result_beats.pop_front();
        if (event_res_o !== want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, event_res_o);
          mismatches++;
        end
        if (out_channel_o !== want.ch) begin
          $error("out_channel: expected %0d, got %0d", want.ch, out_channel_o);
          mismatches++;
        end
        if (payload_byte_o !== want.payload) begin
          $error("payload_byte: expected %0h, got %0h", want.payload, payload_byte_o);
          mismatches++;
        end
        if (byte_offset_o !== want.off) begin
          $error("byte_offset: expected %0d, got %0d", want.off, byte_offset_o);
          mismatches++;
        end
        if (message_length_o !== want.len) begin
          $error("message_length: expected %0d, got %0d", want.len, message_length_o);
          mismatches++;
        end
        if (message_done_o !== want.done) begin
          $error("message_done: expected %0b, got %0b", want.done, message_done_o);
          mismatches++;
        end
        if (fc_block_size_o !== want.bs) begin
          $error("fc_block_size: expected %0d, got %0d", want.bs, fc_block_size_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if no beat moves on any channel for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((frame_valid && !in_stall_o) || (out_valid_o && !res_stall) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb_isotp_receive_reassembler NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = isotp_pkg::CFG_BLOCK_SIZE;
    cfg_data    = '0;
    frame_valid = 1'b0;
    frame_ch    = '0;
    frame_len   = '0;
    frame_bytes = '0;
    // reset values of the shadow state
    bs_reg      = 8'd8;
    max_len_reg = 7'd8;
    receiving   = 1'b0;
    next_sn     = isotp_pkg::SEQ_RESET;
    msg_pos     = isotp_pkg::BYTES_RESET;
    msg_total   = '0;
    block_left  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_block_size();
    test_frame_limit();
    test_backpressure();
    test_random();

    drain_results();
    if (mismatches == 0) begin
      $display("tb_isotp_receive_reassembler OK");
    end else begin
      $display("tb_isotp_receive_reassembler NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
sv/isotp_pkg.sv
sv/isotp_front.sv
sv/isotp_queue.sv
sv/isotp_back.sv
sv/isotp_receive_reassembler.sv
tb/sv/tb_isotp_receive_reassembler.sv
